>>> sv/gated_photon_afterpulse_counter_defines.svh
// Assertion macros for the checker file of the gated counter.
`ifndef GATED_PHOTON_AFTERPULSE_COUNTER_DEFINES_SVH
`define GATED_PHOTON_AFTERPULSE_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define GPAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define GPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/gpac_pkg.sv
package gpac_pkg;

	// Converter word layout.
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CHAN_LSB = 28;
	localparam int unsigned CHAN_W   = 3;
	localparam logic [CHAN_W-1:0] CHAN_COMMON = 3'd0;
	localparam logic [CHAN_W-1:0] CHAN_MARKER = 3'd7;

	// Configuration register widths and indexes.
	localparam int unsigned PERIOD_W  = 28;
	localparam int unsigned GATES_W   = 16;
	localparam int unsigned CFG_W     = 28;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GATES_PER_CYC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SELECTED_GATE = 2'd2;

	// Operation carried in tuser.
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_READ     = 1'b1;

	// Result beat: three clipped counts.
	localparam int unsigned OUT_CNT_W = 32;
	localparam int unsigned OUT_W     = 3 * OUT_CNT_W;

endpackage

>>> sv/gpac_divider.sv
module gpac_divider #(
	parameter int unsigned DW = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DW-1:0]                 dividend,
	input  logic [gpac_pkg::PERIOD_W-1:0] divisor,
	output logic                          done,
	output logic [DW-1:0]                 quotient,
	output logic [gpac_pkg::PERIOD_W-1:0] remainder
);
	import gpac_pkg::*;

	localparam int unsigned CNT_W = $clog2(DW + 1);

	logic [DW-1:0]       num_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [PERIOD_W:0]   trial;
	logic                ge;
	logic [PERIOD_W:0]   diff;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	assign trial = {rem_q, num_q[DW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], ge};
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

>>> sv/gated_photon_afterpulse_counter.sv
// Gated photon / afterpulse counter. Each slave beat carries a converter word in tdata and
// the operation in tuser (0 classify, 1 read and clear). A classified word on channels 1 to 6
// adds one to the total and then to either the photon or the afterpulse count, depending on
// whether its gate slot, (time / gate_period_ticks) mod gates_per_cycle, equals
// selected_gate - 1. If gate_period_ticks, gates_per_cycle or selected_gate is zero, every
// such word is an afterpulse. A read beat returns the three counts on the master side (each
// clipped to 32 bits) and clears them. Reads, dropped words and words under a zero setting
// are handled without leaving the idle state. Any other word goes through two passes of one
// restoring divider that retires one quotient bit per cycle: the first divides the time by
// the gate period, the second reduces that quotient modulo the number of gates. tready stays
// low while the passes run. A finished read result is held in an output register, and a
// further beat is taken while it waits unless that beat is itself a read. Counters saturate
// at their maximum. The user must write registers through the cfg port only while the block
// is idle; the block itself does not enforce this.
module gated_photon_afterpulse_counter #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned TIME_WIDTH  = 28
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gpac_pkg::WORD_W-1:0]    s_tdata,   // [31:0] sample_word
	input  logic                           s_tuser,   // [0] op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [gpac_pkg::OUT_W-1:0]     m_tdata,   // [31:0] total_count,
	                                                  // [63:32] photon_count,
	                                                  // [95:64] afterpulse_count
	input  logic                           cfg_we,
	input  logic [gpac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpac_pkg::CFG_W-1:0]     cfg_wdata
);
	import gpac_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_TIME,
		ST_DIV_SLOT
	} state_t;

	state_t state_q;

	logic [PERIOD_W-1:0] period_q;
	logic [GATES_W-1:0]  gates_q;
	logic [GATES_W-1:0]  sel_gate_q;

	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] photon_q;
	logic [COUNT_WIDTH-1:0] after_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic                  accept;
	logic                  is_read;
	logic [CHAN_W-1:0]     chan;
	logic                  physical;
	logic                  cfg_ok;
	logic                  div_start;
	logic [TIME_WIDTH-1:0] div_dividend;
	logic [PERIOD_W-1:0]   div_divisor;
	logic                  div_done;
	logic [TIME_WIDTH-1:0] div_quot;
	logic [PERIOD_W-1:0]   div_rem;
	logic                  hit;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_CNT_W-1:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_CNT_W-1:0];
	endfunction

	// A read may only enter once the previous result has gone or is leaving now.
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready || (s_tuser != OP_READ));
	assign accept   = s_tvalid && s_tready;
	assign is_read  = (s_tuser == OP_READ);
	assign chan     = s_tdata[CHAN_LSB +: CHAN_W];
	assign physical = (chan != CHAN_COMMON) && (chan != CHAN_MARKER);
	assign cfg_ok   = (period_q != '0) && (gates_q != '0) && (sel_gate_q != '0);

	assign div_start    = (accept && !is_read && physical && cfg_ok) ||
	                      ((state_q == ST_DIV_TIME) && div_done);
	assign div_dividend = (state_q == ST_IDLE) ? s_tdata[TIME_WIDTH-1:0] : div_quot;
	assign div_divisor  = (state_q == ST_IDLE) ? period_q : PERIOD_W'(gates_q);

	// The slot is below gates_per_cycle, so it fits the gate width whenever it matches.
	assign hit = (div_rem == PERIOD_W'(sel_gate_q - 1'b1));

	gpac_divider #(
		.DW(TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_W'(1);
			gates_q    <= GATES_W'(1);
			sel_gate_q <= GATES_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GATE_PERIOD:   period_q   <= cfg_wdata[PERIOD_W-1:0];
				REG_GATES_PER_CYC: gates_q    <= cfg_wdata[GATES_W-1:0];
				REG_SELECTED_GATE: sel_gate_q <= cfg_wdata[GATES_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			photon_q    <= '0;
			after_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && is_read) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_read) begin
							total_q  <= '0;
							photon_q <= '0;
							after_q  <= '0;
						end else if (physical) begin
							total_q <= sat_inc(total_q);
							if (cfg_ok) begin
								state_q <= ST_DIV_TIME;
							end else begin
								after_q <= sat_inc(after_q);
							end
						end
					end
				end
				ST_DIV_TIME: begin
					if (div_done) begin
						state_q <= ST_DIV_SLOT;
					end
				end
				ST_DIV_SLOT: begin
					if (div_done) begin
						state_q <= ST_IDLE;
						if (hit) begin
							photon_q <= sat_inc(photon_q);
						end else begin
							after_q <= sat_inc(after_q);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_read) begin
			out_data_q <= {clip_out(after_q), clip_out(photon_q), clip_out(total_q)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> sv/gpac_checker.sv
`include "gated_photon_afterpulse_counter_defines.svh"

module gpac_sva (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [gpac_pkg::OUT_W-1:0]     m_tdata,
	input logic                           cfg_we,
	input logic [gpac_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [gpac_pkg::CFG_W-1:0]     cfg_wdata
);
	import gpac_pkg::*;

	logic read_beat;
	logic cfg_seen;

	assign read_beat = s_tvalid && s_tready && (s_tuser == OP_READ);
	// A write of zero to the gate period is excluded from the back-to-back read check below.
	assign cfg_seen  = cfg_we && (cfg_index == REG_GATE_PERIOD) && (cfg_wdata == '0);

	// A result that has not been taken holds.
	`GPAC_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// Every read beat produces a result on the next cycle.
	`GPAC_ASSERT_NEXT(a_read_gives_result, read_beat, m_tvalid, "read beat produced no result")

	// A result appears only after a read beat.
	`GPAC_ASSERT_IMP(a_result_from_read, $rose(m_tvalid), $past(read_beat), "result without a read beat")

	// Two reads in consecutive cycles: the second sees counters that were just cleared.
	`GPAC_ASSERT_NEXT(a_back_to_back_read_zero, read_beat ##1 (read_beat && !cfg_seen), m_tdata == '0, "second read did not see cleared counters")

endmodule

bind gated_photon_afterpulse_counter gpac_sva u_gpac_sva (.*);
